// ----- src/rbd_pkg.sv -----
// Package for the ring buffer deque: command and status codes, word types.
`default_nettype none
package rbd_pkg;

    localparam int DATA_W = 32;
    localparam int CNT_W  = 5;

    localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [CNT_W-1:0]         CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        CMD_INS_FRONT = 2'd0,
        CMD_INS_REAR  = 2'd1,
        CMD_REM_FRONT = 2'd2,
        CMD_REM_REAR  = 2'd3
    } t_cmd_code;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd_code                 cmd;
        logic signed [DATA_W-1:0]  value;
    } t_item;

    typedef struct packed {
        logic signed [DATA_W-1:0]  data;
        t_status                   status;
        logic [CNT_W-1:0]          occupancy;
    } t_result;

endpackage
`default_nettype wire

// ----- src/ring_buffer_deque.sv -----
// Top level of the ring buffer deque: control registers, ring store, result register.
`default_nettype none
// Double-ended queue of 32-bit words kept in a ring store of DEPTH words, of
// which the first "capacity" slots are in use (capacity 0 acts as 1, values
// above DEPTH act as DEPTH). A command word is taken at every rising edge
// with start high and busy low; busy stays low, so one command is taken per
// cycle, back to back. Each command gives exactly one result word, shown on
// o_result for one cycle with o_done high, in the cycle right after the
// command was taken: a removal reads the store on the accept edge through
// the store's registered read port. The receiver cannot stall; results must
// be taken when o_done is high. An insert into a full deque is refused
// (status full, data zero); a removal from an empty deque returns the most
// negative word (status empty). Every result carries the occupancy after
// the command. Writing the capacity register (always ready) empties the
// deque; write it only with no command in flight. Store contents are not
// reset and are never read before being written.
module ring_buffer_deque #(
    parameter int DEPTH = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // command channel
    input  wire                 start,
    output logic                busy,
    input  rbd_pkg::t_item      i_item,
    // result channel
    output logic                o_done,
    output rbd_pkg::t_result    o_result,
    // capacity register write channel
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire [4:0]           i_cfg_data
);
    import rbd_pkg::*;

    localparam int AW      = $clog2(DEPTH);
    // largest ring in use: bounded by the store and by the register width
    localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;

    // ring store, one write and one registered read per cycle
    logic signed [DATA_W-1:0] mem [DEPTH];

    logic [CNT_W-1:0]         r_capacity;
    logic [CNT_W-1:0]         r_head, n_head;
    logic [CNT_W-1:0]         r_count, n_count;

    // result register; data of a good removal comes from the read register
    logic                     r_done;
    logic                     r_from_mem;
    logic signed [DATA_W-1:0] r_data, n_data;
    t_status                  r_status, n_status;
    logic [CNT_W-1:0]         r_occ;
    logic signed [DATA_W-1:0] r_rd_data;

    logic                     w_accept;
    logic                     w_cfg_wr;
    logic [CNT_W-1:0]         w_cap;
    logic [CNT_W:0]           w_sum;
    logic [CNT_W:0]           w_wrap;
    logic [CNT_W-1:0]         w_slot;
    logic                     w_we;
    logic                     w_re;
    // slot actually addressed this cycle (front removals use head, front inserts head - 1, rear ops the sum)
    logic [CNT_W-1:0]         w_slot_q;
    logic [AW-1:0]            w_addr;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    // effective ring size
    always_comb begin
        if (r_capacity == '0) begin
            w_cap = CNT_W'(1);
        end else if (r_capacity > CNT_W'(CAP_MAX)) begin
            w_cap = CNT_W'(CAP_MAX);
        end else begin
            w_cap = r_capacity;
        end
    end

    // rear slot: head + count for an insert, head + count - 1 for a removal;
    // the sum stays below twice the ring size, so one subtract wraps it
    always_comb begin
        if (i_item.cmd == CMD_REM_REAR) begin
            w_sum = {1'b0, r_head} + {1'b0, r_count} - (CNT_W+1)'(1);
        end else begin
            w_sum = {1'b0, r_head} + {1'b0, r_count};
        end
        w_wrap = w_sum - {1'b0, w_cap};
        w_slot = (w_sum >= {1'b0, w_cap}) ? w_wrap[CNT_W-1:0] : w_sum[CNT_W-1:0];
    end

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_data   = '0;
        n_status = ST_DONE;
        w_we     = 1'b0;
        w_re     = 1'b0;
        w_slot_q = w_slot;
        case (i_item.cmd)
            CMD_INS_FRONT, CMD_INS_REAR: begin
                if (r_count >= w_cap) begin
                    n_status = ST_FULL;
                end else begin
                    w_we    = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    if (i_item.cmd == CMD_INS_FRONT) begin
                        n_head   = (r_head == '0) ? w_cap - CNT_W'(1)
                                                  : r_head - CNT_W'(1);
                        w_slot_q = n_head;
                    end
                end
            end
            CMD_REM_FRONT, CMD_REM_REAR: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                    n_data   = INT_MIN;
                end else begin
                    w_re    = 1'b1;
                    n_count = r_count - CNT_W'(1);
                    if (i_item.cmd == CMD_REM_FRONT) begin
                        w_slot_q = r_head;
                        n_head   = (r_head + CNT_W'(1) == w_cap) ? '0
                                                                 : r_head + CNT_W'(1);
                    end
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    assign w_addr = AW'(w_slot_q);

    always_ff @(posedge i_clk) begin
        if (w_accept && w_we) begin
            mem[w_addr] <= i_item.value;
        end
        if (w_accept && w_re) begin
            r_rd_data <= mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
            r_head     <= '0;
            r_count    <= '0;
            r_done     <= 1'b0;
            r_from_mem <= 1'b0;
        end else begin
            r_done <= w_accept;
            if (w_cfg_wr) begin
                r_capacity <= i_cfg_data;
                r_head     <= '0;
                r_count    <= '0;
            end else if (w_accept) begin
                r_head     <= n_head;
                r_count    <= n_count;
                r_from_mem <= w_re;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data   <= n_data;
            r_status <= n_status;
            r_occ    <= n_count;
        end
    end

    assign o_done             = r_done;
    assign o_result.data      = r_from_mem ? r_rd_data : r_data;
    assign o_result.status    = r_status;
    assign o_result.occupancy = r_occ;

endmodule
`default_nettype wire

// ----- src/rbd_checker.sv -----
// Port-level checker for the ring buffer deque and its bind to the top level.
`default_nettype none
module rbd_checker (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    input  wire                 busy,
    input  wire                 o_done,
    input  rbd_pkg::t_result    o_result
);
    import rbd_pkg::*;

    // every taken command gives a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("no result after a taken command");

    // no result without a command taken in the cycle before
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy))
        else $error("result word without a command");

    // refused removal: empty deque, most negative word
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_EMPTY) |->
            (o_result.occupancy == '0 && o_result.data == INT_MIN))
        else $error("bad empty removal word");

    // refused insert: deque holds entries, data zero
    a_full_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_FULL) |->
            (o_result.occupancy != '0 && o_result.data == '0))
        else $error("bad full insert word");

endmodule

bind ring_buffer_deque rbd_checker u_rbd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the ring buffer deque: directed and random commands, scoreboard.
module tb;
    import rbd_pkg::*;

    localparam int RING_DEPTH = 16;
    // generous stop time: far beyond the slowest legal run
    localparam int STOP_AFTER = 400000;

    // ---------------------------------------------------------------
    // clock, reset and DUT-facing signals (all known from time zero)
    // ---------------------------------------------------------------
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      start       = 1'b0;
    logic      busy;
    t_item     cmd_word    = '0;
    logic      o_done;
    t_result   o_result;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic [4:0] i_cfg_data = '0;

    always #1 i_clk = ~i_clk;

    ring_buffer_deque #(
        .DEPTH(RING_DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (cmd_word),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // ---------------------------------------------------------------
    // predictor state: our own copy of the ring, front slot, fill level
    // and the capacity register
    // ---------------------------------------------------------------
    logic signed [31:0] ring [RING_DEPTH];
    int unsigned        front_slot = 0;
    int unsigned        fill       = 0;
    logic [4:0]         cap_reg    = CAP_RESET;

    t_item   pending_cmds[$];     // commands waiting for the driver
    t_result awaited_results[$];  // predicted words, oldest first

    bit  took     = 1'b0;  // command word accepted at the last rising edge
    bit  no_idle  = 1'b0;  // phase runs back to back without sender gaps
    int  errors   = 0;
    int  n_checked = 0;
    int  n_full   = 0;
    int  n_empty  = 0;
    int  n_caps   = 1;

    // Apply one command to the predicted deque and return the result word.
    // Rear removal slot is front + fill - 1, so insert-front then
    // remove-rear on an empty deque reads the slot just written.
    function automatic t_result deque_apply(t_item it);
        t_result     r;
        int unsigned slots;
        int unsigned slot;
        // capacity 0 acts as 1, anything above the ring depth as the depth
        if (cap_reg == 5'd0)
            slots = 1;
        else if (cap_reg > RING_DEPTH)
            slots = RING_DEPTH;
        else
            slots = cap_reg;
        r.data   = '0;
        r.status = ST_DONE;
        if (it.cmd == CMD_INS_FRONT || it.cmd == CMD_INS_REAR) begin
            if (fill >= slots) begin
                r.status = ST_FULL;    // refused, nothing moves
            end else begin
                if (it.cmd == CMD_INS_FRONT) begin
                    front_slot = (front_slot + slots - 1) % slots;
                    slot = front_slot;
                end else begin
                    slot = (front_slot + fill) % slots;
                end
                ring[slot] = it.value;
                fill++;
            end
        end else begin
            if (fill == 0) begin
                r.status = ST_EMPTY;   // refused, answers the most negative word
                r.data   = INT_MIN;
            end else begin
                if (it.cmd == CMD_REM_FRONT) begin
                    slot = front_slot;
                    front_slot = (front_slot + 1) % slots;
                end else begin
                    slot = (front_slot + fill - 1) % slots;
                end
                r.data = ring[slot];
                fill--;
            end
        end
        r.occupancy = fill[4:0];
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // ---------------------------------------------------------------
    // monitor: everything sampled at the rising edge; inputs only move
    // on the falling edge so there is no ordering hazard
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            took = 1'b0;
        end else begin
            // result word of the command accepted in the cycle before
            if (o_done) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result word, actual %h", $time, o_result);
                    errors++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("data", want.data, o_result.data);
                    check_field("status", 32'(want.status), 32'(o_result.status));
                    check_field("occupancy", 32'(want.occupancy), 32'(o_result.occupancy));
                    n_checked++;
                    if (want.status == ST_FULL)  n_full++;
                    if (want.status == ST_EMPTY) n_empty++;
                end
            end
            // capacity write empties the deque; store contents are kept
            if (i_cfg_valid && o_cfg_ready) begin
                cap_reg    = i_cfg_data;
                front_slot = 0;
                fill       = 0;
            end
            took = start && !busy;
            if (took)
                awaited_results.push_back(deque_apply(cmd_word));
        end
    end

    // Gap after a command: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // ---------------------------------------------------------------
    // driver: falling edge; start is written once per edge so a word
    // that follows back to back keeps start high
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        static int gap_left = 0;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !took) begin
            // hold the word until busy lets it in
        end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left--;
        end else if (pending_cmds.size() > 0) begin
            cmd_word <= pending_cmds.pop_front();
            start    <= 1'b1;
            gap_left = pick_gap();
        end else begin
            start <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // stimulus sequencing
    // ---------------------------------------------------------------
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return INT_MIN;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_item mk_cmd(t_cmd_code c, logic signed [31:0] v);
        t_item it;
        it.cmd   = c;
        it.value = v;
        return it;
    endfunction

    // Random commands in chunks, each chunk leaning toward inserts or
    // removals so the deque swings between full and empty.
    task automatic queue_random(int n);
        int ins_pct;
        t_cmd_code c;
        for (int i = 0; i < n; i++) begin
            if (i % 25 == 0)
                case ($urandom_range(0, 2))
                    0: ins_pct = 20;
                    1: ins_pct = 50;
                    default: ins_pct = 80;
                endcase
            if ($urandom_range(0, 99) < ins_pct)
                c = $urandom_range(0, 1) ? CMD_INS_REAR : CMD_INS_FRONT;
            else
                c = $urandom_range(0, 1) ? CMD_REM_REAR : CMD_REM_FRONT;
            // removals carry random payload too; the block must ignore it
            pending_cmds.push_back(mk_cmd(c, pick_value()));
        end
    endtask

    // Sender holds off until every predicted word has come back.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_cmds.size() != 0 || start || awaited_results.size() != 0);
    endtask

    task automatic write_capacity(logic [4:0] v);
        wait_idle();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        n_caps++;
        @(posedge i_clk);
    endtask

    initial begin
        logic [4:0] caps [9];
        caps = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd17, 5'd8, 5'd2, 5'd0};
        caps[8] = 5'($urandom_range(1, 16));

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset capacity: empty removals on both ends, the
        // insert-front / remove-rear corner, field extremes
        pending_cmds.push_back(mk_cmd(CMD_REM_FRONT, 32'sh1234_5678));
        pending_cmds.push_back(mk_cmd(CMD_REM_REAR,  -32'sd1));
        pending_cmds.push_back(mk_cmd(CMD_INS_FRONT, 32'sh7fff_ffff));
        pending_cmds.push_back(mk_cmd(CMD_REM_REAR,  '0));
        pending_cmds.push_back(mk_cmd(CMD_INS_REAR,  INT_MIN));
        pending_cmds.push_back(mk_cmd(CMD_INS_FRONT, '0));
        pending_cmds.push_back(mk_cmd(CMD_INS_REAR,  -32'sd1));
        pending_cmds.push_back(mk_cmd(CMD_INS_FRONT, 32'sh5555_5555));
        pending_cmds.push_back(mk_cmd(CMD_INS_REAR,  32'shaaaa_aaaa));
        pending_cmds.push_back(mk_cmd(CMD_REM_FRONT, '0));
        pending_cmds.push_back(mk_cmd(CMD_REM_REAR,  '0));
        pending_cmds.push_back(mk_cmd(CMD_REM_FRONT, '0));
        pending_cmds.push_back(mk_cmd(CMD_REM_REAR,  '0));
        pending_cmds.push_back(mk_cmd(CMD_REM_FRONT, '0));
        pending_cmds.push_back(mk_cmd(CMD_REM_REAR,  '0));

        for (int p = 0; p < 9; p++) begin
            write_capacity(caps[p]);
            no_idle = (p == 1);
            if (p == 0) begin
                // single slot: full refusals on both ends, then drain
                pending_cmds.push_back(mk_cmd(CMD_INS_REAR,  32'sd1));
                pending_cmds.push_back(mk_cmd(CMD_INS_FRONT, 32'sd2));
                pending_cmds.push_back(mk_cmd(CMD_INS_REAR,  32'sd3));
                pending_cmds.push_back(mk_cmd(CMD_REM_REAR,  '0));
                pending_cmds.push_back(mk_cmd(CMD_INS_FRONT, INT_MIN));
                pending_cmds.push_back(mk_cmd(CMD_REM_FRONT, '0));
                pending_cmds.push_back(mk_cmd(CMD_REM_FRONT, '0));
            end
            queue_random(100);
        end

        wait_idle();
        repeat (4) @(posedge i_clk);
        $display("checked %0d result words over %0d capacity settings", n_checked, n_caps);
        $display("refusals seen: %0d full inserts, %0d empty removals", n_full, n_empty);
        if (errors == 0)
            $display("ring_buffer_deque test passed");
        else
            $display("ring_buffer_deque test failed");
        $finish;
    end

    // watchdog
    initial begin
        #STOP_AFTER;
        $display("%0t: timeout, %0d result words still awaited", $time,
                 awaited_results.size());
        $display("ring_buffer_deque test failed");
        $finish;
    end

endmodule
